// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the interval coalescer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define NIC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("interval coalescer assertion failed");

// Hold a signal stable in the cycle after a condition.
`define NIC_ASSERT_HOLD(lbl, clk, rstn, cond, sig) \
  `NIC_ASSERT(lbl, clk, rstn, (cond) |=> $stable(sig))

`endif

// ===== rtl/nic_pkg.sv =====
// ----------------------------------------------------------------------------
// nic_pkg
// Types, constants and helpers shared by the interval coalescer.
// ----------------------------------------------------------------------------
package nic_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int OFFSET_BITS   = 24;
  localparam int TAG_W         = 16;
  localparam int SLOT_W        = 4;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int RSP_W         = SLOT_W + 2 * OFFSET_BITS + TAG_W + 3;

  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef logic [TAG_W-1:0]       tag_t;
  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  localparam off_t MAX_GAP_RST = OFFSET_BITS'(1024);
  localparam cnt_t FULL_COUNT  = CNT_W'(TABLE_ENTRIES);

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_e;

  typedef enum logic {
    OP_ADD,
    OP_FINISH
  } op_e;

  // Classified request handed from the front end to the table engine.
  typedef struct packed {
    op_e  kind;
    off_t left;
    off_t right;
    tag_t tag;
  } op_t;

  typedef struct packed {
    off_t left;
    off_t right;
    tag_t tag;
  } entry_t;

  typedef struct packed {
    slot_t slot;
    off_t  left;
    off_t  right;
    tag_t  tag;
    logic  merged;
    logic  overflow;
    logic  last;
  } rsp_t;

  // Distance from range [l,r) to interval [il,ir); zero on overlap.
  function automatic off_t gap_of(off_t l, off_t r, off_t il, off_t ir);
    off_t d;
    d = '0;
    if (l <= il) begin
      if (il > r) d = il - r;
    end else if (r >= ir) begin
      if (l > ir) d = l - ir;
    end
    return d;
  endfunction

endpackage

// ===== rtl/nic_if.sv =====
// ----------------------------------------------------------------------------
// nic_if
// Request and response channels of the interval coalescer.
// ----------------------------------------------------------------------------
interface nic_req_if;
  logic                valid;
  logic                ready;
  logic                cmd;
  nic_pkg::off_t       range_left;
  nic_pkg::off_t       range_right;
  nic_pkg::tag_t       file_tag;

  modport source (output valid, cmd, range_left, range_right, file_tag, input ready);
  modport sink   (input valid, cmd, range_left, range_right, file_tag, output ready);
endinterface

interface nic_rsp_if;
  logic                valid;
  logic                ready;
  nic_pkg::slot_t      slot;
  nic_pkg::off_t       out_left;
  nic_pkg::off_t       out_right;
  nic_pkg::tag_t       out_tag;
  logic                merged;
  logic                overflow;
  logic                last;

  modport source (output valid, slot, out_left, out_right, out_tag, merged, overflow, last,
                  input ready);
  modport sink   (input valid, slot, out_left, out_right, out_tag, merged, overflow, last,
                  output ready);
endinterface

// ===== rtl/nic_front.sv =====
// ----------------------------------------------------------------------------
// nic_front
// Accept requests, classify them and buffer them in a short queue.
// ----------------------------------------------------------------------------
module nic_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  nic_req_if.sink       req_i,
  output logic          op_valid_o,
  output nic_pkg::op_t  op_o,
  input  logic          op_pop_i
);

  nic_pkg::op_t                  queue_q [nic_pkg::QUEUE_DEPTH];
  logic [nic_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [nic_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [nic_pkg::QCNT_W-1:0]    fill_q, fill_d;
  nic_pkg::op_t                  op_new;
  logic                          push, pop;

  // Decode the command.
  always_comb begin
    op_new.left  = req_i.range_left;
    op_new.right = req_i.range_right;
    op_new.tag   = req_i.file_tag;
    unique case (req_i.cmd)
      nic_pkg::CMD_ADD:    op_new.kind = nic_pkg::OP_ADD;
      nic_pkg::CMD_FINISH: op_new.kind = nic_pkg::OP_FINISH;
      default:             op_new.kind = nic_pkg::OP_ADD;
    endcase
  end

  assign req_i.ready = (fill_q != nic_pkg::QCNT_W'(nic_pkg::QUEUE_DEPTH));
  assign push        = req_i.valid && req_i.ready;
  assign op_valid_o  = (fill_q != '0);
  assign pop         = op_pop_i && op_valid_o;
  assign op_o        = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) fill_d = fill_q + 1'b1;
    if (pop && !push) fill_d = fill_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) queue_q[wr_ptr_q] <= op_new;
  end

endmodule

// ===== rtl/nic_back.sv =====
// ----------------------------------------------------------------------------
// nic_back
// Interval table engine: nearest-interval scan, merge or append, and flush.
// ----------------------------------------------------------------------------
module nic_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           op_valid_i,
  input  nic_pkg::op_t   op_i,
  output logic           op_pop_o,
  input  nic_pkg::off_t  max_gap_i,
  output logic           rsp_valid_o,
  output nic_pkg::rsp_t  rsp_o,
  input  logic           rsp_ready_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_EM_RD,
    S_EM_WR
  } state_e;

  state_e          state_q, state_d;
  nic_pkg::cnt_t   count_q, count_d;
  nic_pkg::cnt_t   iss_q, iss_d;
  logic            chk_vld_q, chk_vld_d;
  nic_pkg::idx_t   chk_idx_q, chk_idx_d;
  logic            found_q, found_d;
  logic            out_vld_q, out_vld_d;

  nic_pkg::op_t    item_q, item_d;
  nic_pkg::idx_t   best_idx_q, best_idx_d;
  nic_pkg::off_t   best_gap_q, best_gap_d;
  nic_pkg::entry_t best_q, best_d;
  nic_pkg::rsp_t   out_q, out_d;

  nic_pkg::entry_t mem [nic_pkg::TABLE_ENTRIES];
  nic_pkg::entry_t rd_q;
  logic            rd_en, wr_en;
  nic_pkg::idx_t   rd_addr, wr_addr;
  nic_pkg::entry_t wr_data;

  nic_pkg::off_t   gap;
  nic_pkg::off_t   wide_l, wide_r;
  logic            out_free;
  logic            em_last;

  assign gap      = nic_pkg::gap_of(item_q.left, item_q.right, rd_q.left, rd_q.right);
  assign wide_l   = (item_q.left < best_q.left) ? item_q.left : best_q.left;
  assign wide_r   = (item_q.right > best_q.right) ? item_q.right : best_q.right;
  assign out_free = !out_vld_q || rsp_ready_i;
  assign em_last  = (iss_q == count_q - nic_pkg::CNT_W'(1));

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    iss_d      = iss_q;
    chk_vld_d  = chk_vld_q;
    chk_idx_d  = chk_idx_q;
    found_d    = found_q;
    item_d     = item_q;
    best_idx_d = best_idx_q;
    best_gap_d = best_gap_q;
    best_d     = best_q;
    out_vld_d  = out_vld_q && !rsp_ready_i;
    out_d      = out_q;
    op_pop_o   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = iss_q[nic_pkg::IDX_W-1:0];
    wr_en      = 1'b0;
    wr_addr    = best_idx_q;
    wr_data    = '{left: item_q.left, right: item_q.right, tag: item_q.tag};

    unique case (state_q)
      S_IDLE: begin
        if (op_valid_i) begin
          op_pop_o  = 1'b1;
          item_d    = op_i;
          iss_d     = '0;
          chk_vld_d = 1'b0;
          found_d   = 1'b0;
          unique case (op_i.kind)
            nic_pkg::OP_ADD:    state_d = S_SCAN;
            nic_pkg::OP_FINISH: state_d = (count_q == '0) ? S_IDLE : S_EM_RD;
            default:            state_d = S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        // Issue one slot read a cycle; compare the slot read last cycle.
        chk_vld_d = 1'b0;
        if (iss_q < count_q) begin
          rd_en     = 1'b1;
          iss_d     = iss_q + 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = iss_q[nic_pkg::IDX_W-1:0];
        end
        if (chk_vld_q && (!found_q || gap < best_gap_q)) begin
          found_d    = 1'b1;
          best_idx_d = chk_idx_q;
          best_gap_d = gap;
          best_d     = rd_q;
        end
        if (iss_q == count_q && !chk_vld_q) state_d = S_DECIDE;
      end

      S_DECIDE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
          if (found_q && best_gap_q < max_gap_i) begin
            wr_en   = 1'b1;
            wr_addr = best_idx_q;
            wr_data = '{left: wide_l, right: wide_r, tag: best_q.tag};
            out_d   = '{slot: nic_pkg::SLOT_W'(best_idx_q), left: wide_l, right: wide_r,
                        tag: best_q.tag, merged: 1'b1, overflow: 1'b0, last: 1'b1};
          end else if (count_q == nic_pkg::FULL_COUNT) begin
            // Table full: drop the range and flag it.
            out_d   = '{slot: '0, left: item_q.left, right: item_q.right,
                        tag: item_q.tag, merged: 1'b0, overflow: 1'b1, last: 1'b1};
          end else begin
            wr_en   = 1'b1;
            wr_addr = count_q[nic_pkg::IDX_W-1:0];
            count_d = count_q + 1'b1;
            out_d   = '{slot: nic_pkg::SLOT_W'(count_q[nic_pkg::IDX_W-1:0]),
                        left: item_q.left, right: item_q.right, tag: item_q.tag,
                        merged: 1'b0, overflow: 1'b0, last: 1'b1};
          end
        end
      end

      S_EM_RD: begin
        rd_en   = 1'b1;
        state_d = S_EM_WR;
      end

      S_EM_WR: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = '{slot: nic_pkg::SLOT_W'(iss_q[nic_pkg::IDX_W-1:0]), left: rd_q.left,
                        right: rd_q.right, tag: rd_q.tag, merged: 1'b0, overflow: 1'b0,
                        last: em_last};
          if (em_last) begin
            count_d = '0;
            state_d = S_IDLE;
          end else begin
            iss_d   = iss_q + 1'b1;
            state_d = S_EM_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      iss_q      <= '0;
      chk_vld_q  <= 1'b0;
      chk_idx_q  <= '0;
      found_q    <= 1'b0;
      out_vld_q  <= 1'b0;
      item_q     <= '0;
      best_idx_q <= '0;
      best_gap_q <= '0;
      best_q     <= '0;
      out_q      <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      iss_q      <= iss_d;
      chk_vld_q  <= chk_vld_d;
      chk_idx_q  <= chk_idx_d;
      found_q    <= found_d;
      out_vld_q  <= out_vld_d;
      item_q     <= item_d;
      best_idx_q <= best_idx_d;
      best_gap_q <= best_gap_d;
      best_q     <= best_d;
      out_q      <= out_d;
    end
  end

  // Interval table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  assign rsp_valid_o = out_vld_q;
  assign rsp_o       = out_q;

endmodule

// ===== rtl/nearest_interval_coalescer.sv =====
// ----------------------------------------------------------------------------
// nearest_interval_coalescer
// Coalesce byte ranges of one file into a small table of intervals.
// ----------------------------------------------------------------------------
// An add request carries a range [range_left, range_right) and a file tag.
// The block scans the table for the interval nearest to the range (gap zero
// on overlap or containment, lowest slot on a tie); if that gap is below
// max_gap the interval is widened to cover the range and a response with
// merged set is returned, otherwise the range is appended as a new interval,
// or, with all 16 slots taken, dropped and reported with overflow set (slot
// 0, the dropped range and tag). A finish request returns every stored
// interval in slot order, last set on the final one, and empties the table;
// on an empty table it returns nothing. An add has the table engine fetch
// the request, read each stored slot in turn through the single read port
// of the interval memory, drain the last compare and then update; a finish
// reads and returns each stored interval in turn. A two-entry request queue
// in front of the engine and a response register behind it let either side
// stall on its own.
// max_gap resets to 1024 and is written through cfg_we_i / cfg_wdata_i; the
// user must write it only while the block is idle, which the block itself
// does not enforce. The interval table needs no clearing after reset.
// ----------------------------------------------------------------------------
module nearest_interval_coalescer (
  input  logic           clk_i,
  input  logic           rst_ni,
  nic_req_if.sink        req_i,
  nic_rsp_if.source      rsp_o,
  input  logic           cfg_we_i,
  input  nic_pkg::off_t  cfg_wdata_i
);

  nic_pkg::off_t  max_gap_q;
  logic           op_valid;
  logic           op_pop;
  nic_pkg::op_t   op;
  logic           rsp_valid;
  nic_pkg::rsp_t  rsp;

  // Merge threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gap_q <= nic_pkg::MAX_GAP_RST;
    end else if (cfg_we_i) begin
      max_gap_q <= cfg_wdata_i;
    end
  end

  // Front end: accept and classify requests, queue them.
  nic_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  // Table engine: scan, merge or append, flush.
  nic_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_i        (op),
    .op_pop_o    (op_pop),
    .max_gap_i   (max_gap_q),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp),
    .rsp_ready_i (rsp_o.ready)
  );

  // Drive the response channel from the engine's output register.
  assign rsp_o.valid     = rsp_valid;
  assign rsp_o.slot      = rsp.slot;
  assign rsp_o.out_left  = rsp.left;
  assign rsp_o.out_right = rsp.right;
  assign rsp_o.out_tag   = rsp.tag;
  assign rsp_o.merged    = rsp.merged;
  assign rsp_o.overflow  = rsp.overflow;
  assign rsp_o.last      = rsp.last;

endmodule

// ===== rtl/nic_checker.sv =====
// ----------------------------------------------------------------------------
// nic_checker
// Port-level checks on the interval coalescer response channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nic_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rsp_valid_i,
  input  logic            rsp_ready_i,
  input  nic_pkg::slot_t  rsp_slot_i,
  input  nic_pkg::off_t   rsp_left_i,
  input  nic_pkg::off_t   rsp_right_i,
  input  nic_pkg::tag_t   rsp_tag_i,
  input  logic            rsp_merged_i,
  input  logic            rsp_overflow_i,
  input  logic            rsp_last_i
);

  logic [nic_pkg::RSP_W-1:0] rsp_pay;
  logic                      add_rsp;
  logic                      add_ok;

  assign rsp_pay = {rsp_slot_i, rsp_left_i, rsp_right_i, rsp_tag_i,
                    rsp_merged_i, rsp_overflow_i, rsp_last_i};
  assign add_rsp = rsp_valid_i && (rsp_merged_i || rsp_overflow_i);
  assign add_ok  = rsp_last_i && (!rsp_overflow_i || rsp_slot_i == '0);

  // Hold a stalled response.
  `NIC_ASSERT(rsp_hold_valid, clk_i, rst_ni, (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i)
  `NIC_ASSERT_HOLD(rsp_hold_data, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_pay)

  // A response never reports both a merge and an overflow.
  `NIC_ASSERT(rsp_flag_excl, clk_i, rst_ni, rsp_valid_i |-> !(rsp_merged_i && rsp_overflow_i))

  // Merge and overflow come from adds: single final response; overflow in slot 0.
  `NIC_ASSERT(rsp_add_last, clk_i, rst_ni, add_rsp |-> add_ok)

endmodule

bind nearest_interval_coalescer nic_checker u_nic_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_slot_i     (rsp_o.slot),
  .rsp_left_i     (rsp_o.out_left),
  .rsp_right_i    (rsp_o.out_right),
  .rsp_tag_i      (rsp_o.out_tag),
  .rsp_merged_i   (rsp_o.merged),
  .rsp_overflow_i (rsp_o.overflow),
  .rsp_last_i     (rsp_o.last)
);

// ===== tb/sv/nearest_interval_coalescer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_interval_coalescer_tb
// Self-checking bench for the interval coalescer. Named tests drive add and
// finish requests through the request channel, a predictor mirrors the
// interval table and the max_gap register, and a checker compares each
// response field by field with the oldest predicted one. Both channels idle
// and stall at random; max_gap is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module nearest_interval_coalescer_tb;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 4;
  localparam int IDLE_PCT       = 7;
  // A finish on an empty table gives no response, so let the engine settle
  // for longer than a full-table add before touching max_gap.
  localparam int ENGINE_SETTLE  = 40;
  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_LIMIT    = 100;
  localparam nic_pkg::off_t GAP_MAX = '1;

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  nic_pkg::off_t cfg_wdata_i;

  nic_req_if req_if ();
  nic_rsp_if rsp_if ();

  nearest_interval_coalescer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Mirror of the interval table and of max_gap.
  nic_pkg::off_t iv_left  [nic_pkg::TABLE_ENTRIES];
  nic_pkg::off_t iv_right [nic_pkg::TABLE_ENTRIES];
  nic_pkg::tag_t iv_tag   [nic_pkg::TABLE_ENTRIES];
  int unsigned   iv_count;
  nic_pkg::off_t gap_limit;

  // Responses still owed by the block, oldest first.
  nic_pkg::rsp_t pending_rsp[$];

  int unsigned sent_requests;
  int unsigned mismatch_count;
  int unsigned sender_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned quiet_cycles;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  // Distance from range [l,r) to interval [il,ir), zero on overlap or
  // containment. Work in 64 bits so reversed ranges give a clean negative.
  function automatic longint range_distance(nic_pkg::off_t l, nic_pkg::off_t r,
                                            nic_pkg::off_t il, nic_pkg::off_t ir);
    longint a;
    longint b;
    longint d;
    d = 0;
    if (l <= il) begin
      a = longint'(il);
      b = longint'(r);
      d = a - b;
    end else if (r >= ir) begin
      a = longint'(l);
      b = longint'(ir);
      d = a - b;
    end
    return (d > 0) ? d : 0;
  endfunction

  function automatic nic_pkg::rsp_t make_rsp(int unsigned s, nic_pkg::off_t l,
                                             nic_pkg::off_t r, nic_pkg::tag_t t,
                                             logic m, logic o, logic e);
    nic_pkg::rsp_t x;
    x.slot     = nic_pkg::slot_t'(s);
    x.left     = l;
    x.right    = r;
    x.tag      = t;
    x.merged   = m;
    x.overflow = o;
    x.last     = e;
    return x;
  endfunction

  // Append a predicted response behind the ones already owed.
  task automatic queue_rsp(nic_pkg::rsp_t x);
    pending_rsp = {pending_rsp, x};
  endtask

  // Merge into the nearest interval, append a new one, or flag a full table.
  task automatic coalesce_range(nic_pkg::off_t l, nic_pkg::off_t r, nic_pkg::tag_t t);
    bit          found;
    int unsigned best;
    longint      best_gap;
    longint      g;
    longint      limit;
    found    = 1'b0;
    best     = 0;
    best_gap = 0;
    limit    = longint'(gap_limit);
    for (int unsigned i = 0; i < iv_count; i++) begin
      g = range_distance(l, r, iv_left[i], iv_right[i]);
      // strict compare keeps the lowest slot on a tie
      if (!found || g < best_gap) begin
        found    = 1'b1;
        best     = i;
        best_gap = g;
      end
    end
    if (found && best_gap < limit) begin
      if (l < iv_left[best]) iv_left[best] = l;
      if (r > iv_right[best]) iv_right[best] = r;
      queue_rsp(make_rsp(best, iv_left[best], iv_right[best], iv_tag[best],
                         1'b1, 1'b0, 1'b1));
    end else if (iv_count >= nic_pkg::TABLE_ENTRIES) begin
      queue_rsp(make_rsp(0, l, r, t, 1'b0, 1'b1, 1'b1));
    end else begin
      iv_left[iv_count]  = l;
      iv_right[iv_count] = r;
      iv_tag[iv_count]   = t;
      queue_rsp(make_rsp(iv_count, l, r, t, 1'b0, 1'b0, 1'b1));
      iv_count++;
    end
  endtask

  // Emit the stored intervals in slot order and empty the table.
  task automatic flush_intervals();
    for (int unsigned i = 0; i < iv_count; i++) begin
      queue_rsp(make_rsp(i, iv_left[i], iv_right[i], iv_tag[i],
                         1'b0, 1'b0, (i + 1 == iv_count)));
    end
    iv_count = 0;
  endtask

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  // Hold valid until the request is taken, then predict its responses. Valid
  // is left high on return so a following request goes out back to back;
  // idling or a quiet wait lowers it.
  task automatic send_request(nic_pkg::cmd_e c, nic_pkg::off_t l, nic_pkg::off_t r,
                              nic_pkg::tag_t t);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.cmd         <= c;
    req_if.range_left  <= l;
    req_if.range_right <= r;
    req_if.file_tag    <= t;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    sent_requests++;
    if (c == nic_pkg::CMD_FINISH) flush_intervals();
    else coalesce_range(l, r, t);
  endtask

  // Drop valid and hold off until every predicted response has arrived.
  task automatic wait_quiet();
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Rewrite max_gap with the block idle.
  task automatic set_gap_limit(nic_pkg::off_t value);
    wait_quiet();
    repeat (ENGINE_SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    gap_limit   = value;
  endtask

  // --------------------------------------------------------------------------
  // Response checker
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("[%0t] response error: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic check_response();
    nic_pkg::rsp_t want;
    if (pending_rsp.size() == 0) begin
      report_mismatch($sformatf("unexpected response on slot %0d", rsp_if.slot));
      return;
    end
    want = pending_rsp.pop_front();
    check_field("slot", 32'(rsp_if.slot), 32'(want.slot));
    check_field("out_left", 32'(rsp_if.out_left), 32'(want.left));
    check_field("out_right", 32'(rsp_if.out_right), 32'(want.right));
    check_field("out_tag", 32'(rsp_if.out_tag), 32'(want.tag));
    check_field("merged", 32'(rsp_if.merged), 32'(want.merged));
    check_field("overflow", 32'(rsp_if.overflow), 32'(want.overflow));
    check_field("last", 32'(rsp_if.last), 32'(want.last));
  endtask

  // Sample the handshake as it stood at the edge, then pick the next ready.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) check_response();
      rsp_if.ready <= (rst_ni === 1'b1) && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog: count cycles in which neither channel moves anything.
  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $time, quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // A finish on an empty table must give no response at all.
  task automatic test_empty_finish();
    send_request(nic_pkg::CMD_FINISH, GAP_MAX, GAP_MAX, 16'hFFFF);
  endtask

  // Merge rules under the reset max_gap of 1024: gap one below the limit
  // merges, gap equal to it opens a new slot, an equal-distance range goes to
  // the lower slot, a contained range leaves the interval alone, and a
  // reversed range is used as given.
  task automatic test_merge_rules();
    send_request(nic_pkg::CMD_ADD, 24'd100, 24'd200, 16'hA5A5);
    send_request(nic_pkg::CMD_ADD, 24'd1223, 24'd1250, 16'h0001);
    send_request(nic_pkg::CMD_ADD, 24'd2274, 24'd2300, 16'h5A5A);
    send_request(nic_pkg::CMD_ADD, 24'd1700, 24'd1824, 16'h0002);
    send_request(nic_pkg::CMD_ADD, 24'd500, 24'd600, 16'h0003);
    send_request(nic_pkg::CMD_ADD, 24'd3000, 24'd2900, 16'h0004);
    send_request(nic_pkg::CMD_FINISH, '0, '0, '0);
  endtask

  // With max_gap zero nothing merges: fill all slots, then overflow once.
  task automatic test_table_overflow();
    nic_pkg::off_t l;
    set_gap_limit('0);
    for (int unsigned i = 0; i < nic_pkg::TABLE_ENTRIES; i++) begin
      l = nic_pkg::off_t'(i * 24'h0F0F0F);
      send_request(nic_pkg::CMD_ADD, l, l + nic_pkg::off_t'(i),
                   nic_pkg::tag_t'(16'hFFFF >> i));
    end
    send_request(nic_pkg::CMD_ADD, GAP_MAX, '0, 16'hFFFF);
    send_request(nic_pkg::CMD_FINISH, '0, '0, '0);
  endtask

  // Largest max_gap: the widest possible gap still fails the strict compare.
  task automatic test_limit_extremes();
    set_gap_limit(GAP_MAX);
    send_request(nic_pkg::CMD_ADD, '0, '0, '0);
    send_request(nic_pkg::CMD_ADD, GAP_MAX, GAP_MAX, 16'hFFFF);
    send_request(nic_pkg::CMD_FINISH, '0, '0, '0);
  endtask

  // One file: adds clustered around a base with random spread, some reversed
  // or wild ranges and odd tags mixed in, then a finish, sometimes followed
  // by a stray finish on the now empty table.
  task automatic send_random_file(int unsigned adds);
    nic_pkg::tag_t t;
    nic_pkg::off_t base;
    nic_pkg::off_t l;
    nic_pkg::off_t r;
    nic_pkg::off_t sw;
    int unsigned   spread;
    t    = nic_pkg::tag_t'($urandom);
    base = nic_pkg::off_t'($urandom);
    case ($urandom_range(3))
      0: spread = 256;
      1: spread = 4096;
      2: spread = 65536;
      default: spread = 24'hFFFFFF;
    endcase
    for (int unsigned k = 0; k < adds; k++) begin
      l = base + nic_pkg::off_t'($urandom_range(spread));
      r = l + nic_pkg::off_t'($urandom_range(600));
      case ($urandom_range(19))
        0: begin
          sw = l;
          l  = r;
          r  = sw;
        end
        1: begin
          l = nic_pkg::off_t'($urandom);
          r = nic_pkg::off_t'($urandom);
        end
        default: ;
      endcase
      send_request(nic_pkg::CMD_ADD, l, r,
                   ($urandom_range(15) == 0) ? nic_pkg::tag_t'($urandom) : t);
    end
    send_request(nic_pkg::CMD_FINISH, nic_pkg::off_t'($urandom), nic_pkg::off_t'($urandom),
                 nic_pkg::tag_t'($urandom));
    if ($urandom_range(5) == 0) begin
      send_request(nic_pkg::CMD_FINISH, nic_pkg::off_t'($urandom),
                   nic_pkg::off_t'($urandom), nic_pkg::tag_t'($urandom));
    end
  endtask

  task automatic test_random_files(nic_pkg::off_t limit, int unsigned budget);
    int unsigned start;
    set_gap_limit(limit);
    start = sent_requests;
    while (sent_requests - start < budget) send_random_file($urandom_range(1, 20));
  endtask

  // Long stretch with no idling on either side.
  task automatic test_back_to_back(int unsigned budget);
    int unsigned start;
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    start = sent_requests;
    while (sent_requests - start < budget) send_random_file($urandom_range(1, 20));
    wait_quiet();
    sender_idle_pct = IDLE_PCT;
    sink_stall_pct  = IDLE_PCT;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    req_if.valid       <= 1'b0;
    req_if.cmd         <= nic_pkg::CMD_ADD;
    req_if.range_left  <= '0;
    req_if.range_right <= '0;
    req_if.file_tag    <= '0;
    iv_count        = 0;
    gap_limit       = nic_pkg::MAX_GAP_RST;
    sent_requests   = 0;
    mismatch_count  = 0;
    sender_idle_pct = IDLE_PCT;
    sink_stall_pct  = IDLE_PCT;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_finish();
    test_merge_rules();
    test_table_overflow();
    test_limit_extremes();
    test_random_files(nic_pkg::off_t'($urandom_range(1, 4096)), 10);
    test_random_files(nic_pkg::off_t'(1), 10);
    test_random_files(nic_pkg::off_t'($urandom), 10);
    test_random_files(nic_pkg::MAX_GAP_RST, 10);
    test_back_to_back(10);

    // The last test has drained; allow for any late stray response.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
